@@ rtl/satq_pkg.sv @@
// ----------------------------------------------------------------------------
// Sorted alarm timer queue package
// Request and result types, queue entry, command and status codes.
// ----------------------------------------------------------------------------
package satq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned RESULT_CAP      = 16;
  localparam int unsigned NW              = $clog2(RESULT_CAP + 1);

  localparam logic [29:0] NS_PER_SEC = 30'd1000000000;
  localparam logic [29:0] NS_TOP     = 30'd999999999;

  localparam logic [1:0] CMD_POST   = 2'd0;
  localparam logic [1:0] CMD_TICK   = 2'd1;
  localparam logic [1:0] CMD_FLUSH  = 2'd2;
  localparam logic [1:0] CMD_CANCEL = 2'd3;

  localparam logic [1:0] TYPE_ABS = 2'd0;
  localparam logic [1:0] TYPE_REL = 2'd1;

  localparam logic [3:0] ST_QUEUED    = 4'd0;
  localparam logic [3:0] ST_DUE_NOW   = 4'd1;
  localparam logic [3:0] ST_INVALID   = 4'd2;
  localparam logic [3:0] ST_FULL      = 4'd3;
  localparam logic [3:0] ST_EXPIRED   = 4'd4;
  localparam logic [3:0] ST_FLUSHED   = 4'd5;
  localparam logic [3:0] ST_CANCELLED = 4'd6;
  localparam logic [3:0] ST_NOT_FOUND = 4'd7;
  localparam logic [3:0] ST_NONE_DUE  = 4'd8;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] now_sec;
    logic [29:0] now_nsec;
    logic [1:0]  alarm_mode;
    logic [31:0] alarm_sec;
    logic [29:0] alarm_nsec;
    logic        alarm_kind;
    logic [7:0]  tag;
  } req_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [7:0]  tag_res;
    logic        alarm_kind_res;
    logic [31:0] deadline_sec;
    logic [29:0] deadline_nsec;
    logic        next_valid;
    logic [31:0] next_sec;
    logic [29:0] next_nsec;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [31:0] sec;
    logic [29:0] nsec;
    logic        kind;
    logic [7:0]  tag;
  } entry_t;

endpackage

@@ rtl/sorted_alarm_timer_queue_unit.sv @@
// ----------------------------------------------------------------------------
// Sorted alarm timer queue
// Deadline-ordered alarm queue in a circular buffer memory, walked one entry
// at a time by a sequencer around one shared time comparator.
// ----------------------------------------------------------------------------
//  channel   ports                     handshake
//  request   start, busy, req_i        taken when start && !busy
//  result    res_valid_o, res_o        each result valid for a single cycle, last marks the end
//
// A queued post computes and normalises the deadline, checks it against now, then walks from the tail,
// moving each entry with a later deadline back by one; a refused or due post skips the walk.
// A tick or flush pops the expired entries one by one, or gives a none-due result when nothing is due.
// A cancel searches by tag from the head, then moves each later entry forward (not-found if absent).
// Reset empties the queue at once; the entry memory itself is not cleared.
// Results cannot be stalled; busy stays high until the last one is driven.
module sorted_alarm_timer_queue_unit
  import satq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  req_t req_i,
  output logic busy,
  output logic res_valid_o,
  output res_t res_o
);

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SW = CW + 1;
  localparam logic [SW-1:0] DepthS = SW'(QUEUE_DEPTH);
  localparam logic [CW-1:0] DepthC = CW'(QUEUE_DEPTH);
  localparam logic [NW-1:0] CapLast = NW'(RESULT_CAP - 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CALC  = 4'd1;
  localparam logic [3:0] S_NORM  = 4'd2;
  localparam logic [3:0] S_CHECK = 4'd3;
  localparam logic [3:0] S_IRD   = 4'd4;
  localparam logic [3:0] S_ICMP  = 4'd5;
  localparam logic [3:0] S_IPUT  = 4'd6;
  localparam logic [3:0] S_TCHK  = 4'd7;
  localparam logic [3:0] S_TPOP  = 4'd8;
  localparam logic [3:0] S_CRD   = 4'd9;
  localparam logic [3:0] S_CCMP  = 4'd10;
  localparam logic [3:0] S_SRD   = 4'd11;
  localparam logic [3:0] S_SWR   = 4'd12;
  localparam logic [3:0] S_CDONE = 4'd13;

  function automatic logic [PW-1:0] phys(input logic [PW-1:0] base, input logic [CW-1:0] l);
    logic [SW-1:0] s;
    s = SW'(base) + SW'(l);
    if (s >= DepthS) s = s - DepthS;
    return s[PW-1:0];
  endfunction

  function automatic res_t mk_res(input logic [3:0] st, input logic [7:0] t, input logic k,
                                 input logic [31:0] ds, input logic [29:0] dn,
                                 input logic nv, input entry_t nx, input logic lst);
    res_t r;
    r.status         = st;
    r.tag_res        = t;
    r.alarm_kind_res = k;
    r.deadline_sec   = ds;
    r.deadline_nsec  = dn;
    r.next_valid     = nv;
    r.next_sec       = nv ? nx.sec : 32'd0;
    r.next_nsec      = nv ? nx.nsec : 30'd0;
    r.last           = lst;
    return r;
  endfunction

  logic [3:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [PW-1:0] hp_q, hp_d;
  logic          res_vld_q, res_vld_d;
  res_t          res_q, res_d;
  req_t          req_q, req_d;
  logic [31:0]   dl_s_q, dl_s_d;
  logic [30:0]   dl_n_q, dl_n_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [NW-1:0] n_q, n_d;
  entry_t        head_q, head_d;
  entry_t        fnd_q, fnd_d;
  entry_t        rd_q;
  entry_t        mem_q [QUEUE_DEPTH];

  logic          we_c;
  entry_t        wd_c;
  logic [CW-1:0] rl_c;
  entry_t        new_c;
  entry_t        cmp_a, cmp_b;
  logic          cmp_gt, cmp_eq;
  logic          tpop_last;

  assign new_c = '{sec: dl_s_q, nsec: dl_n_q[29:0], kind: req_q.alarm_kind, tag: req_q.tag};

  always_comb begin
    cmp_b = '{sec: req_q.now_sec, nsec: req_q.now_nsec, kind: 1'b0, tag: 8'd0};
    case (state_q)
      S_CHECK: cmp_a = new_c;
      S_ICMP: begin
        cmp_a = rd_q;
        cmp_b = new_c;
      end
      S_TCHK:  cmp_a = head_q;
      default: cmp_a = rd_q;
    endcase
  end

  assign cmp_eq = (cmp_a.sec == cmp_b.sec) && (cmp_a.nsec == cmp_b.nsec);
  assign cmp_gt = (cmp_a.sec > cmp_b.sec) ||
                  ((cmp_a.sec == cmp_b.sec) && (cmp_a.nsec > cmp_b.nsec));

  assign tpop_last = (cnt_q == '0) || (n_q == CapLast) ||
                     ((req_q.cmd == CMD_TICK) && cmp_gt);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    hp_d      = hp_q;
    res_vld_d = 1'b0;
    res_d     = res_q;
    req_d     = req_q;
    dl_s_d    = dl_s_q;
    dl_n_d    = dl_n_q;
    idx_d     = idx_q;
    n_d       = n_q;
    head_d    = head_q;
    fnd_d     = fnd_q;
    we_c      = 1'b0;
    wd_c      = rd_q;
    rl_c      = idx_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          req_d = req_i;
          if (req_i.now_nsec > NS_TOP) req_d.now_nsec = NS_TOP;
          idx_d = '0;
          n_d   = '0;
          case (req_i.cmd)
            CMD_POST:   state_d = S_CALC;
            CMD_CANCEL: state_d = S_CRD;
            default:    state_d = S_TCHK;
          endcase
        end
      end
      S_CALC: begin
        if (req_q.alarm_mode > TYPE_REL || req_q.alarm_nsec >= NS_PER_SEC) begin
          res_vld_d = 1'b1;
          res_d = mk_res(ST_INVALID, req_q.tag, req_q.alarm_kind, 32'd0, 30'd0,
                         cnt_q != '0, head_q, 1'b1);
          state_d = S_IDLE;
        end else begin
          if (req_q.alarm_mode == TYPE_ABS) begin
            dl_s_d = req_q.alarm_sec;
            dl_n_d = {1'b0, req_q.alarm_nsec};
          end else begin
            dl_s_d = req_q.alarm_sec + req_q.now_sec;
            dl_n_d = {1'b0, req_q.alarm_nsec} + {1'b0, req_q.now_nsec};
          end
          state_d = S_NORM;
        end
      end
      S_NORM: begin
        if (dl_n_q >= {1'b0, NS_PER_SEC}) begin
          dl_n_d = dl_n_q - {1'b0, NS_PER_SEC};
          dl_s_d = dl_s_q + 32'd1;
        end
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (!cmp_gt && !cmp_eq) begin
          res_vld_d = 1'b1;
          res_d = mk_res(ST_INVALID, req_q.tag, req_q.alarm_kind, 32'd0, 30'd0,
                         cnt_q != '0, head_q, 1'b1);
          state_d = S_IDLE;
        end else if (cmp_eq || cnt_q == DepthC) begin
          res_vld_d = 1'b1;
          res_d = mk_res(cmp_eq ? ST_DUE_NOW : ST_FULL, req_q.tag, req_q.alarm_kind,
                         new_c.sec, new_c.nsec, cnt_q != '0, head_q, 1'b1);
          state_d = S_IDLE;
        end else begin
          idx_d   = cnt_q;
          state_d = S_IRD;
        end
      end
      S_IRD: begin
        rl_c = idx_q - CW'(1);
        state_d = (idx_q == '0) ? S_IPUT : S_ICMP;
      end
      S_ICMP: begin
        if (cmp_gt) begin
          we_c    = 1'b1;
          idx_d   = idx_q - CW'(1);
          state_d = S_IRD;
        end else begin
          state_d = S_IPUT;
        end
      end
      S_IPUT: begin
        we_c = 1'b1;
        wd_c = new_c;
        if (idx_q == '0) head_d = new_c;
        cnt_d = cnt_q + CW'(1);
        res_vld_d = 1'b1;
        res_d = mk_res(ST_QUEUED, req_q.tag, req_q.alarm_kind, new_c.sec, new_c.nsec,
                       1'b1, (idx_q == '0) ? new_c : head_q, 1'b1);
        state_d = S_IDLE;
      end
      S_TCHK: begin
        rl_c = CW'(1);
        if (cnt_q != '0 && (req_q.cmd == CMD_FLUSH || !cmp_gt)) begin
          hp_d    = phys(hp_q, CW'(1));
          cnt_d   = cnt_q - CW'(1);
          state_d = S_TPOP;
        end else begin
          res_vld_d = 1'b1;
          res_d = mk_res(ST_NONE_DUE, 8'd0, 1'b0, 32'd0, 30'd0,
                         cnt_q != '0, head_q, 1'b1);
          state_d = S_IDLE;
        end
      end
      S_TPOP: begin
        res_vld_d = 1'b1;
        res_d = mk_res((req_q.cmd == CMD_TICK) ? ST_EXPIRED : ST_FLUSHED, head_q.tag,
                       head_q.kind, head_q.sec, head_q.nsec, cnt_q != '0, rd_q, tpop_last);
        head_d  = rd_q;
        n_d     = n_q + NW'(1);
        state_d = tpop_last ? S_IDLE : S_TCHK;
      end
      S_CRD: begin
        if (idx_q == cnt_q) begin
          res_vld_d = 1'b1;
          res_d = mk_res(ST_NOT_FOUND, req_q.tag, 1'b0, 32'd0, 30'd0,
                         cnt_q != '0, head_q, 1'b1);
          state_d = S_IDLE;
        end else begin
          state_d = S_CCMP;
        end
      end
      S_CCMP: begin
        if (rd_q.tag == req_q.tag) begin
          fnd_d   = rd_q;
          state_d = S_SRD;
        end else begin
          idx_d   = idx_q + CW'(1);
          state_d = S_CRD;
        end
      end
      S_SRD: begin
        rl_c = idx_q + CW'(1);
        state_d = ({1'b0, idx_q} + SW'(1) >= {1'b0, cnt_q}) ? S_CDONE : S_SWR;
      end
      S_SWR: begin
        we_c = 1'b1;
        if (idx_q == '0) head_d = rd_q;
        idx_d   = idx_q + CW'(1);
        state_d = S_SRD;
      end
      S_CDONE: begin
        cnt_d = cnt_q - CW'(1);
        res_vld_d = 1'b1;
        res_d = mk_res(ST_CANCELLED, req_q.tag, fnd_q.kind, fnd_q.sec, fnd_q.nsec,
                       cnt_q > CW'(1), head_q, 1'b1);
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we_c) mem_q[phys(hp_q, idx_q)] <= wd_c;
    rd_q <= mem_q[phys(hp_q, rl_c)];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      hp_q      <= '0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      hp_q      <= hp_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    req_q  <= req_d;
    dl_s_q <= dl_s_d;
    dl_n_q <= dl_n_d;
    idx_q  <= idx_d;
    n_q    <= n_d;
    head_q <= head_d;
    fnd_q  <= fnd_d;
  end

  assign busy        = (state_q != S_IDLE);
  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.last |-> busy)
    else $error("result without last flag while sequencer idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (res_o.next_valid == (cnt_q != '0)))
    else $error("next_valid disagrees with queue occupancy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DepthC)
    else $error("queue occupancy beyond capacity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy && !res_valid_o)
    else $error("request accepted without sequencer start");

endmodule

@@ tb/sv/tb_sorted_alarm_timer_queue_unit.sv @@
// ----------------------------------------------------------------------------
// Sorted alarm timer queue testbench
// Sends post, tick, flush and cancel requests with random idle gaps, predicts
// every result from a behavioural copy of the deadline-ordered queue, and
// checks each result field by field in order of arrival.
// ----------------------------------------------------------------------------
module tb_sorted_alarm_timer_queue_unit;
  import satq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CLK_PERIOD     = 4;
  localparam int unsigned RESET_CYCLES   = 4;
  localparam int unsigned QUEUE_DEPTH    = QUEUE_DEPTH_DEF;
  localparam int unsigned RANDOM_ITEMS   = 440;
  localparam int unsigned DRAIN_CYCLES   = 80;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned MAX_PRINTED    = 30;
  localparam int unsigned TAG_POOL       = 11;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  req_t req_i  = '0;
  logic busy;
  logic res_valid_o;
  res_t res_o;

  entry_t model_alarms[$];
  res_t alarm_res_exp[$];
  res_t res_want;

  int unsigned err_count       = 0;
  int unsigned results_checked = 0;
  int unsigned full_refusals   = 0;
  int unsigned idle_cycles     = 0;
  int unsigned cmd_count[4]    = '{0, 0, 0, 0};
  bit no_idle = 1'b0;

  sorted_alarm_timer_queue_unit #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .req_i      (req_i),
    .busy       (busy),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic int cmp_time(input logic [31:0] a_sec, input logic [29:0] a_ns,
                                  input logic [31:0] b_sec, input logic [29:0] b_ns);
    if (a_sec != b_sec) return (a_sec > b_sec) ? 1 : -1;
    if (a_ns != b_ns) return (a_ns > b_ns) ? 1 : -1;
    return 0;
  endfunction

  function automatic logic [61:0] time_after(input logic [31:0] s, input logic [29:0] ns,
                                             input logic [31:0] ds, input logic [29:0] dns);
    logic [31:0] sec_sum;
    logic [31:0] ns_sum;
    sec_sum = s + ds;
    ns_sum  = {2'b00, ns} + {2'b00, dns};
    if (ns_sum >= {2'b00, NS_PER_SEC}) begin
      ns_sum  = ns_sum - {2'b00, NS_PER_SEC};
      sec_sum = sec_sum + 32'd1;
    end
    return {sec_sum, ns_sum[29:0]};
  endfunction

  function automatic req_t make_request(input logic [1:0] cmd, input logic [31:0] now_s,
                                        input logic [29:0] now_ns, input logic [1:0] typ,
                                        input logic [31:0] a_s, input logic [29:0] a_ns,
                                        input logic kind, input logic [7:0] tag);
    req_t r;
    r.cmd        = cmd;
    r.now_sec    = now_s;
    r.now_nsec   = now_ns;
    r.alarm_mode = typ;
    r.alarm_sec  = a_s;
    r.alarm_nsec = a_ns;
    r.alarm_kind = kind;
    r.tag        = tag;
    return r;
  endfunction

  // next deadline reflects the queue after the action of this result
  task automatic note_alarm_result(input logic [3:0] st, input logic [7:0] tag,
                                   input logic kind, input logic [31:0] ds,
                                   input logic [29:0] dn);
    res_t r;
    r                = '0;
    r.status         = st;
    r.tag_res        = tag;
    r.alarm_kind_res = kind;
    r.deadline_sec   = ds;
    r.deadline_nsec  = dn;
    if (model_alarms.size() > 0) begin
      r.next_valid = 1'b1;
      r.next_sec   = model_alarms[0].sec;
      r.next_nsec  = model_alarms[0].nsec;
    end
    alarm_res_exp.push_back(r);
  endtask

  task automatic predict_alarm_queue(input req_t r);
    logic [29:0] now_ns;
    logic [61:0] dl;
    logic [31:0] dl_sec;
    logic [29:0] dl_ns;
    int c;
    int pos;
    int n;
    entry_t e;
    res_t tail;
    n      = 0;
    now_ns = (r.now_nsec > NS_TOP) ? NS_TOP : r.now_nsec;
    case (r.cmd)
      CMD_POST: begin
        if (r.alarm_mode > TYPE_REL || r.alarm_nsec >= NS_PER_SEC) begin
          note_alarm_result(ST_INVALID, r.tag, r.alarm_kind, '0, '0);
        end else begin
          if (r.alarm_mode == TYPE_REL) begin
            dl = time_after(r.now_sec, now_ns, r.alarm_sec, r.alarm_nsec);
          end else begin
            dl = {r.alarm_sec, r.alarm_nsec};
          end
          dl_sec = dl[61:30];
          dl_ns  = dl[29:0];
          c      = cmp_time(dl_sec, dl_ns, r.now_sec, now_ns);
          if (c < 0) begin
            note_alarm_result(ST_INVALID, r.tag, r.alarm_kind, '0, '0);
          end else if (c == 0) begin
            note_alarm_result(ST_DUE_NOW, r.tag, r.alarm_kind, dl_sec, dl_ns);
          end else if (model_alarms.size() >= QUEUE_DEPTH) begin
            full_refusals++;
            note_alarm_result(ST_FULL, r.tag, r.alarm_kind, dl_sec, dl_ns);
          end else begin
            pos = 0;
            while (pos < model_alarms.size() &&
                   cmp_time(model_alarms[pos].sec, model_alarms[pos].nsec,
                            dl_sec, dl_ns) <= 0) pos++;
            e.sec  = dl_sec;
            e.nsec = dl_ns;
            e.kind = r.alarm_kind;
            e.tag  = r.tag;
            model_alarms.insert(pos, e);
            note_alarm_result(ST_QUEUED, r.tag, r.alarm_kind, dl_sec, dl_ns);
          end
        end
      end
      CMD_TICK, CMD_FLUSH: begin
        while (model_alarms.size() > 0 && n < RESULT_CAP &&
               (r.cmd == CMD_FLUSH ||
                cmp_time(model_alarms[0].sec, model_alarms[0].nsec,
                         r.now_sec, now_ns) <= 0)) begin
          e = model_alarms.pop_front();
          note_alarm_result((r.cmd == CMD_TICK) ? ST_EXPIRED : ST_FLUSHED,
                            e.tag, e.kind, e.sec, e.nsec);
          n++;
        end
        if (n == 0) note_alarm_result(ST_NONE_DUE, '0, 1'b0, '0, '0);
      end
      CMD_CANCEL: begin
        pos = 0;
        while (pos < model_alarms.size() && model_alarms[pos].tag != r.tag) pos++;
        if (pos < model_alarms.size()) begin
          e = model_alarms[pos];
          model_alarms.delete(pos);
          note_alarm_result(ST_CANCELLED, r.tag, e.kind, e.sec, e.nsec);
        end else begin
          note_alarm_result(ST_NOT_FOUND, r.tag, 1'b0, '0, '0);
        end
      end
      default: ;
    endcase
    tail      = alarm_res_exp.pop_back();
    tail.last = 1'b1;
    alarm_res_exp.push_back(tail);
  endtask

  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (no_idle) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // call just after a rising edge; returns just after the accepting edge or the gap
  task automatic send_request(input req_t r);
    int unsigned gap;
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    predict_alarm_queue(r);
    cmd_count[r.cmd]++;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (err_count < MAX_PRINTED) begin
      $display("%0t ns: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    end
    err_count++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      results_checked++;
      if (alarm_res_exp.size() == 0) begin
        report_mismatch("status of a result with none outstanding", 32'(res_o.status), '0);
      end else begin
        res_want = alarm_res_exp.pop_front();
        if (res_o.status !== res_want.status)
          report_mismatch("status", 32'(res_o.status), 32'(res_want.status));
        if (res_o.tag_res !== res_want.tag_res)
          report_mismatch("tag_res", 32'(res_o.tag_res), 32'(res_want.tag_res));
        if (res_o.alarm_kind_res !== res_want.alarm_kind_res)
          report_mismatch("alarm_kind_res", 32'(res_o.alarm_kind_res),
                          32'(res_want.alarm_kind_res));
        if (res_o.deadline_sec !== res_want.deadline_sec)
          report_mismatch("deadline_sec", res_o.deadline_sec, res_want.deadline_sec);
        if (res_o.deadline_nsec !== res_want.deadline_nsec)
          report_mismatch("deadline_nsec", 32'(res_o.deadline_nsec),
                          32'(res_want.deadline_nsec));
        if (res_o.next_valid !== res_want.next_valid)
          report_mismatch("next_valid", 32'(res_o.next_valid), 32'(res_want.next_valid));
        if (res_o.next_sec !== res_want.next_sec)
          report_mismatch("next_sec", res_o.next_sec, res_want.next_sec);
        if (res_o.next_nsec !== res_want.next_nsec)
          report_mismatch("next_nsec", 32'(res_o.next_nsec), 32'(res_want.next_nsec));
        if (res_o.last !== res_want.last)
          report_mismatch("last", 32'(res_o.last), 32'(res_want.last));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || res_valid_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no request or result for %0d cycles", idle_cycles);
      $display("tb_sorted_alarm_timer_queue_unit: done, errors");
      $finish;
    end
  end

  task automatic test_post_checks();
    send_request(make_request(CMD_POST, 32'd5, 30'd0, 2'd2, 32'd9, 30'd0, 1'b0, 8'd0));
    send_request(make_request(CMD_POST, 32'd5, 30'd0, 2'd3, '1, '1, 1'b1, 8'hFF));
    send_request(make_request(CMD_POST, 32'd5, 30'd0, TYPE_ABS, 32'd9, NS_PER_SEC,
                              1'b1, 8'd3));
    // relative seconds wrap past the top and land before now
    send_request(make_request(CMD_POST, 32'hFFFF_FFF0, 30'd10, TYPE_REL, 32'h20, 30'd0,
                              1'b0, 8'd4));
    send_request(make_request(CMD_POST, 32'd8, 30'd123, TYPE_ABS, 32'd8, 30'd123,
                              1'b1, 8'd5));
    // out-of-range now nanoseconds clamp, so a zero interval is due now
    send_request(make_request(CMD_POST, '1, '1, TYPE_REL, 32'd0, 30'd0, 1'b0, 8'd6));
    send_request(make_request(CMD_POST, 32'd10, NS_TOP, TYPE_REL, 32'd0, NS_TOP,
                              1'b1, 8'd9));
  endtask

  task automatic test_fill_and_full();
    int i;
    logic [29:0] dl_ns;
    for (i = 0; i < 14; i++) begin
      dl_ns = 30'((i % 3) * 250_000_000);
      send_request(make_request(CMD_POST, 32'd100, 30'd0, TYPE_ABS, 32'(101 + i % 4), dl_ns,
                                i[0], (i % 5 == 0) ? 8'd7 : 8'(i)));
    end
    send_request(make_request(CMD_POST, 32'd100, 30'd0, TYPE_ABS, '1, NS_TOP, 1'b1, 8'hFF));
    send_request(make_request(CMD_POST, 32'd100, 30'd0, TYPE_REL, 32'd1, 30'd0, 1'b0, 8'd0));
  endtask

  task automatic test_cancel();
    send_request(make_request(CMD_CANCEL, 32'd100, 30'd0, TYPE_ABS, '0, '0, 1'b0, 8'd7));
    send_request(make_request(CMD_CANCEL, 32'd100, 30'd0, TYPE_ABS, '0, '0, 1'b1, 8'd200));
  endtask

  task automatic test_expire_and_flush();
    send_request(make_request(CMD_TICK, 32'd102, 30'd250_000_000, TYPE_ABS, '0, '0,
                              1'b0, 8'd0));
    send_request(make_request(CMD_FLUSH, 32'd0, 30'd0, TYPE_ABS, '0, '0, 1'b0, 8'd0));
    send_request(make_request(CMD_TICK, '1, NS_TOP, TYPE_ABS, '0, '0, 1'b1, 8'd1));
    send_request(make_request(CMD_FLUSH, '1, '1, TYPE_ABS, '0, '0, 1'b1, 8'd1));
  endtask

  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned i;
    int unsigned pick;
    logic [31:0] t_sec;
    logic [29:0] t_ns;
    logic [31:0] off_s;
    logic [29:0] off_ns;
    logic [61:0] dl;
    logic [159:0] raw;
    req_t r;
    t_sec = $urandom;
    t_ns  = 30'($urandom_range(0, NS_TOP));
    for (i = 0; i < n_items; i++) begin
      if (i % 60 == 0) no_idle = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      r = make_request(CMD_POST, t_sec, t_ns, TYPE_ABS, '0, '0, 1'($urandom_range(0, 1)),
                       8'($urandom_range(0, TAG_POOL)));
      if (pick < 55) begin
        off_s  = $urandom_range(0, 3);
        off_ns = 30'($urandom_range(0, NS_TOP));
        if ($urandom_range(0, 9) == 0) begin
          off_s  = '0;
          off_ns = '0;
        end
        if ($urandom_range(0, 1)) begin
          r.alarm_mode = TYPE_REL;
          r.alarm_sec  = off_s;
          r.alarm_nsec = off_ns;
        end else begin
          dl           = time_after(t_sec, t_ns, off_s, off_ns);
          r.alarm_sec  = dl[61:30];
          r.alarm_nsec = dl[29:0];
        end
      end else if (pick < 75) begin
        dl       = time_after(t_sec, t_ns, $urandom_range(0, 1),
                              30'($urandom_range(0, NS_TOP)));
        t_sec    = dl[61:30];
        t_ns     = dl[29:0];
        r.cmd      = CMD_TICK;
        r.now_sec  = t_sec;
        r.now_nsec = t_ns;
      end else if (pick < 85) begin
        r.cmd = CMD_CANCEL;
        if ($urandom_range(0, 3) == 0) r.tag = 8'($urandom_range(0, 255));
      end else if (pick < 89) begin
        r.cmd = CMD_FLUSH;
      end else begin
        case ($urandom_range(0, 4))
          0: begin
            r.alarm_mode = 2'($urandom_range(2, 3));
            r.alarm_sec  = $urandom;
            r.alarm_nsec = 30'($urandom);
          end
          1: begin
            r.alarm_mode = 2'($urandom_range(0, 1));
            r.alarm_nsec = 30'($urandom_range(NS_PER_SEC, 30'h3FFF_FFFF));
          end
          2: begin
            raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
            r   = raw[$bits(req_t)-1:0];
          end
          3: begin
            r.alarm_sec  = t_sec - 32'd1 - $urandom_range(0, 100);
            r.alarm_nsec = 30'($urandom_range(0, NS_TOP));
          end
          default: begin
            t_sec      = $urandom;
            t_ns       = 30'($urandom_range(0, NS_TOP));
            r.cmd      = CMD_TICK;
            r.now_sec  = t_sec;
            r.now_nsec = t_ns;
          end
        endcase
      end
      send_request(r);
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_post_checks();
    test_fill_and_full();
    test_cancel();
    test_expire_and_flush();
    test_random_traffic(RANDOM_ITEMS);
    start <= 1'b0;
    while (alarm_res_exp.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("requests sent: %0d posts (%0d refused as full), %0d ticks, %0d flushes, %0d cancels",
             cmd_count[CMD_POST], full_refusals, cmd_count[CMD_TICK], cmd_count[CMD_FLUSH],
             cmd_count[CMD_CANCEL]);
    $display("results compared: %0d, mismatches: %0d", results_checked, err_count);
    if (err_count == 0) begin
      $display("tb_sorted_alarm_timer_queue_unit: done, clean");
    end else begin
      $display("tb_sorted_alarm_timer_queue_unit: done, errors");
    end
    $finish;
  end

endmodule
